FILE: hdl/ddr_pkg.sv
// Package with the shared types and constants of the daily dimming ramp.
`default_nettype none

package ddr_pkg;

    // Day length in seconds and the scale value that stands for 1.0.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] LAST_SECOND  = 17'd86399;
    localparam logic [15:0] SCALE_ONE    = 16'd32768;

    // The day is 675 times 128 seconds. The upper 25 bits of a time are
    // reduced modulo 675 with a multiply by ceil(2^35 / 675) and a shift by 35.
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam logic [9:0]  DAY_ODD   = 10'd675;

    // Reset values of the configuration registers.
    localparam logic [16:0] RESET_RAMP = 17'd3600;
    localparam logic [15:0] RESET_MIN  = 16'd6540;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DAY_START = 3'd0;
    localparam logic [2:0] CFG_DAY_END   = 3'd1;
    localparam logic [2:0] CFG_RISE_TIME = 3'd2;
    localparam logic [2:0] CFG_FALL_TIME = 3'd3;
    localparam logic [2:0] CFG_MIN_SCALE = 3'd4;

    // Width of the divider dividend and quotient.
    localparam int DIV_W = 33;

    // Segment of the day that the result belongs to.
    typedef enum logic [2:0] {
        PH_RISE  = 3'd0,
        PH_FALL  = 3'd1,
        PH_FULL  = 3'd2,
        PH_MIN   = 3'd3,
        PH_OTHER = 3'd4,
        PH_HELD  = 3'd5
    } phase_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_REM,
        ST_CLASS,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [16:0] day_start;
        logic [16:0] day_end;
        logic [16:0] rise_time;
        logic [16:0] fall_time;
        logic [15:0] min_scale;
    } cfg_t;

    // Classification of one time of day.
    typedef struct packed {
        logic        same;
        phase_t      phase;
        logic [16:0] elapsed;
        logic [16:0] divisor;
        logic [15:0] mn;
        logic [15:0] inv;
    } win_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [16:0]      divisor;
    } div_req_t;

    // Response of the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/daily_dimming_ramp.sv
// Top level of the daily dimming ramp: registers, sequencer and output stage.
//
// The input stream carries one time in seconds per transfer on s_tdata. For
// each one the block returns one 1.15 brightness scale on m_tdata and the
// day segment it belongs to on m_tuser.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, as the block does not enforce it.
// Indexes beyond the register list are ignored. The time is reduced modulo
// the day with a reciprocal multiply in ST_MOD and ST_REM, and the segment is
// picked in ST_CLASS. On a ramp or the other segment one shared restoring
// divider then divides the product of the elapsed time and the scale span by
// the ramp length in 33 steps. A flat segment skips the divider, and when day
// start equals day end the block goes from the input transfer straight to the
// finish. s_tready is low while an item is in work and rises when the result
// is loaded, so the next item is accepted only then.
// The result waits in an output register, so a stalled receiver does not
// stop the next input transfer; the block finishes that item and then waits,
// with s_tready low, for the register to drain.
// Reset restores the register defaults and clears the held scale to zero.
`default_nettype none

module daily_dimming_ramp
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] time_seconds
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] scale_factor
    output logic [2:0]       m_tuser,   // [2:0] phase
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    import ddr_pkg::*;

    state_t      state_reg, state_next;
    cfg_t        cfg_reg;
    logic [31:0] tsec_reg, tsec_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] tod_reg, tod_next;
    phase_t      phase_reg, phase_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [16:0] divisor_reg, divisor_next;
    logic [15:0] mn_reg, mn_next;
    logic [15:0] inv_reg, inv_next;
    logic [DIV_W-1:0] prod_reg, prod_next;
    logic [15:0] held_reg, held_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] scale_out_reg, scale_out_next;
    phase_t      phase_out_reg, phase_out_next;
    win_t        win;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        in_xfer;
    logic        out_free;
    logic [15:0] q_sat;
    logic [16:0] rise_sum;
    logic [15:0] fin_scale;
    logic [50:0] recip_prod;
    logic [24:0] days_mul;
    logic [24:0] hi_rem;

    ddr_window u_window
    (
        .tod (tod_reg),
        .cfg (cfg_reg),
        .win (win)
    );

    ddr_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Whole days in the time, then the remainder of the upper bits modulo 675.
    assign recip_prod = {26'd0, tsec_reg[31:7]} * {25'd0, DAY_RECIP};
    assign days_mul   = {9'd0, days_reg} * {15'd0, DAY_ODD};
    assign hi_rem     = tsec_reg[31:7] - days_mul;

    // Final scale from the quotient, saturated at 1.0.
    assign q_sat    = (div_rsp.quotient > {{(DIV_W-16){1'b0}}, SCALE_ONE})
                      ? SCALE_ONE : div_rsp.quotient[15:0];
    assign rise_sum = {1'b0, q_sat} + {1'b0, mn_reg};

    always_comb
    begin
        case (phase_reg)
            PH_RISE, PH_OTHER:
                fin_scale = (rise_sum > {1'b0, SCALE_ONE}) ? SCALE_ONE : rise_sum[15:0];
            PH_FALL:
                fin_scale = SCALE_ONE - q_sat;
            PH_FULL:
                fin_scale = SCALE_ONE;
            PH_MIN:
                fin_scale = mn_reg;
            default:
                fin_scale = held_reg;
        endcase
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.day_start <= '0;
            cfg_reg.day_end   <= '0;
            cfg_reg.rise_time <= RESET_RAMP;
            cfg_reg.fall_time <= RESET_RAMP;
            cfg_reg.min_scale <= RESET_MIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DAY_START: cfg_reg.day_start <= cfg_data;
                CFG_DAY_END:   cfg_reg.day_end   <= cfg_data;
                CFG_RISE_TIME: cfg_reg.rise_time <= cfg_data;
                CFG_FALL_TIME: cfg_reg.fall_time <= cfg_data;
                CFG_MIN_SCALE: cfg_reg.min_scale <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Sequencer: next state, divider requests and output stage.
    always_comb
    begin
        state_next       = state_reg;
        tsec_next        = tsec_reg;
        days_next        = days_reg;
        tod_next         = tod_reg;
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        divisor_next     = divisor_reg;
        mn_next          = mn_reg;
        inv_next         = inv_reg;
        prod_next        = prod_reg;
        held_next        = held_reg;
        scale_out_next   = scale_out_reg;
        phase_out_next   = phase_out_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = divisor_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    tsec_next = s_tdata;
                    if (win.same)
                    begin
                        phase_next = PH_HELD;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                days_next  = recip_prod[50:35];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                tod_next   = {hi_rem[9:0], tsec_reg[6:0]};
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                phase_next   = win.phase;
                elapsed_next = win.elapsed;
                divisor_next = win.divisor;
                mn_next      = win.mn;
                inv_next     = win.inv;
                if (win.phase == PH_FULL || win.phase == PH_MIN)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = DIV_W'(elapsed_reg * inv_reg);
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    scale_out_next = fin_scale;
                    phase_out_next = phase_reg;
                    held_next      = fin_scale;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and the held scale.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            held_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            held_reg     <= held_next;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        tsec_reg      <= tsec_next;
        days_reg      <= days_next;
        tod_reg       <= tod_next;
        phase_reg     <= phase_next;
        elapsed_reg   <= elapsed_next;
        divisor_reg   <= divisor_next;
        mn_reg        <= mn_next;
        inv_reg       <= inv_next;
        prod_reg      <= prod_next;
        scale_out_reg <= scale_out_next;
        phase_out_reg <= phase_out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = scale_out_reg;
    assign m_tuser  = phase_out_reg;

`ifndef ASSERT_OFF
    // The divider is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // An input transfer leads into the modulo step or straight to the finish.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_MOD || state_reg == ST_FINISH))
        else $error("unexpected state after input transfer");

    // A loaded result never exceeds 1.0 and the held scale follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=>
            (m_tdata <= SCALE_ONE && held_reg == m_tdata))
        else $error("result above 1.0 or held scale out of step");

    // A held result repeats the scale that was held before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free && phase_reg == PH_HELD) |=>
            (m_tdata == $past(held_reg)))
        else $error("held result differs from held scale");
`endif

endmodule

`default_nettype wire

FILE: hdl/ddr_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module ddr_divider
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ddr_pkg::div_req_t req,
    output ddr_pkg::div_rsp_t      rsp
);
    import ddr_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [16:0]      rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [16:0]      dsr_reg, dsr_next;
    logic [17:0]      partial;
    logic [17:0]      diff;
    logic             ge;

    // One shift, compare and subtract step.
    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = partial >= {1'b0, dsr_reg};
    assign diff    = partial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[16:0] : partial[16:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the data path is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/ddr_window.sv
// Window classifier: picks the day segment and the ramp elapsed time.
`default_nettype none

module ddr_window
(
    input  wire logic [16:0]   tod,
    input  wire ddr_pkg::cfg_t cfg,
    output ddr_pkg::win_t      win
);
    import ddr_pkg::*;

    localparam logic [17:0] DAY18 = {1'b0, SECS_PER_DAY};

    logic [16:0] st, en, rise, fall;
    logic [15:0] mn;
    logic [17:0] up_end, up_p1, up_norm;
    logic [17:0] dn_end, dn_p1, dn_norm;
    logic [17:0] full_base, full_last, night_base, night_last;
    logic [17:0] el_rise, el_fall;
    logic        w_rise, w_fall, w_full, w_night;
    phase_t      ph;

    // True when t lies in [lo, hi], where hi may pass midnight.
    function automatic logic in_win(input logic [17:0] t, input logic [17:0] lo,
                                    input logic [17:0] hi);
        logic [17:0] hi_wrap;
        hi_wrap = hi - DAY18;
        return (lo <= t && t <= hi) || (hi >= DAY18 && t <= hi_wrap);
    endfunction

    // Reduce and clamp the registers.
    assign st   = (cfg.day_start >= SECS_PER_DAY) ? cfg.day_start - SECS_PER_DAY
                                                  : cfg.day_start;
    assign en   = (cfg.day_end >= SECS_PER_DAY) ? cfg.day_end - SECS_PER_DAY
                                                : cfg.day_end;
    assign rise = (cfg.rise_time == '0) ? 17'd1 :
                  (cfg.rise_time > LAST_SECOND) ? LAST_SECOND : cfg.rise_time;
    assign fall = (cfg.fall_time == '0) ? 17'd1 :
                  (cfg.fall_time > LAST_SECOND) ? LAST_SECOND : cfg.fall_time;
    assign mn   = (cfg.min_scale > SCALE_ONE) ? SCALE_ONE : cfg.min_scale;

    // Ramp ends and the first second after each ramp.
    assign up_end  = {1'b0, st} + {1'b0, rise};
    assign up_p1   = up_end + 18'd1;
    assign up_norm = (up_p1 >= DAY18) ? up_p1 - DAY18 : up_p1;
    assign dn_end  = {1'b0, en} + {1'b0, fall};
    assign dn_p1   = dn_end + 18'd1;
    assign dn_norm = (dn_p1 >= DAY18) ? dn_p1 - DAY18 : dn_p1;

    // Last second of the full and night windows, unfolded past midnight.
    assign full_base  = (en == '0) ? {1'b0, LAST_SECOND} : {1'b0, en} - 18'd1;
    assign full_last  = (full_base < up_norm) ? full_base + DAY18 : full_base;
    assign night_base = (st == '0) ? {1'b0, LAST_SECOND} : {1'b0, st} - 18'd1;
    assign night_last = (night_base < dn_norm) ? night_base + DAY18 : night_base;

    assign w_rise  = in_win({1'b0, tod}, {1'b0, st}, up_end);
    assign w_fall  = in_win({1'b0, tod}, {1'b0, en}, dn_end);
    assign w_full  = in_win({1'b0, tod}, up_norm, full_last);
    assign w_night = in_win({1'b0, tod}, dn_norm, night_last);

    // Priority order of the windows.
    always_comb
    begin
        if (w_rise)
            ph = PH_RISE;
        else if (w_fall)
            ph = PH_FALL;
        else if (w_full)
            ph = PH_FULL;
        else if (w_night)
            ph = PH_MIN;
        else
            ph = PH_OTHER;
    end

    // Elapsed time since the ramp start, taken modulo the day.
    assign el_rise = (tod >= st) ? {1'b0, tod} - {1'b0, st}
                                 : {1'b0, tod} + DAY18 - {1'b0, st};
    assign el_fall = (tod >= en) ? {1'b0, tod} - {1'b0, en}
                                 : {1'b0, tod} + DAY18 - {1'b0, en};

    assign win.same    = (st == en);
    assign win.phase   = ph;
    assign win.elapsed = (ph == PH_FALL) ? el_fall[16:0] : el_rise[16:0];
    assign win.divisor = (ph == PH_FALL) ? fall : rise;
    assign win.mn      = mn;
    assign win.inv     = SCALE_ONE - mn;

endmodule

`default_nettype wire

FILE: tb/daily_dimming_ramp_tb.sv
// Self-checking testbench for the daily dimming ramp, with its own scale predictor.
`timescale 1ns / 1ps

module daily_dimming_ramp_tb;
    import ddr_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          ITEMS_PER_CFG = 50;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          TAIL_CYCLES   = 100;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [2:0]  CFG_UNUSED    = 3'd7;
    localparam logic [16:0] CFG_DATA_MAX  = 17'h1FFFF;
    localparam int unsigned DAYS_IN_WORD  = 49709;

    // One result of the block.
    typedef struct {
        logic [15:0] scale;
        phase_t      ph;
    } scale_result_t;

    // One row of the directed table: a register write or a time transfer.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [16:0] val;
        logic [31:0] tsec;
        bit          typed;
        logic [15:0] scale;
        phase_t      ph;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] time_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [15:0] scale_factor
    logic [2:0]  m_tuser;   // [2:0] phase
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // Shadow copy of the registers and the held scale.
    logic [16:0] day_start_r;
    logic [16:0] day_end_r;
    logic [16:0] rise_time_r;
    logic [16:0] fall_time_r;
    logic [15:0] min_scale_r;
    logic [15:0] held_scale;

    scale_result_t pending_scales [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_left = 0;
    bit            hold_req = 1'b0;
    bit            hold_done = 1'b0;

    // Directed table: reset state, a plain day, a ramp crossing midnight,
    // start equal to end, out-of-range registers, and the register extremes.
    localparam int DIR_ROWS = 40;
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{0, CFG_DAY_START, 17'd0,        32'd0,          1, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'hFFFFFFFF,   1, 16'd0,     PH_HELD},
        '{1, CFG_DAY_START, 17'd21600,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_END,   17'd64800,    32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd21600,      1, 16'd6540,  PH_RISE},
        '{0, CFG_DAY_START, 17'd0,        32'd25200,      1, 16'd32768, PH_RISE},
        '{0, CFG_DAY_START, 17'd0,        32'd25201,      1, 16'd32768, PH_FULL},
        '{0, CFG_DAY_START, 17'd0,        32'd64800,      1, 16'd32768, PH_FALL},
        '{0, CFG_DAY_START, 17'd0,        32'd68400,      1, 16'd6540,  PH_FALL},
        '{0, CFG_DAY_START, 17'd0,        32'd68401,      1, 16'd6540,  PH_MIN},
        '{0, CFG_DAY_START, 17'd0,        32'd86399,      1, 16'd6540,  PH_MIN},
        '{0, CFG_DAY_START, 17'd0,        32'hFFFFFFFF,   0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_START, 17'd82800,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_END,   17'd43200,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_RISE_TIME, 17'd7200,     32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_FALL_TIME, 17'd86399,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_MIN_SCALE, 17'd0,        32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd3600,       0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd43199,      0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd44200,      0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_END,   17'd82800,    32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd12345,      0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_START, CFG_DATA_MAX, 32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_END,   17'd0,        32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_RISE_TIME, 17'd0,        32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_FALL_TIME, CFG_DATA_MAX, 32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_MIN_SCALE, CFG_DATA_MAX, 32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_UNUSED,    CFG_DATA_MAX, 32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd44671,      0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd44672,      0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd1,          0, 16'd0,     PH_HELD},
        '{1, CFG_MIN_SCALE, 17'd32768,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_RISE_TIME, 17'd86399,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_START, 17'd86399,    32'd0,          0, 16'd0,     PH_HELD},
        '{1, CFG_DAY_END,   17'd1,        32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd86399,      0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd0,          0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd43200,      0, 16'd0,     PH_HELD},
        '{0, CFG_DAY_START, 17'd0,        32'd2,          0, 16'd0,     PH_HELD}
    };

    daily_dimming_ramp u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A zero duration acts as one second, and no ramp is longer than a day.
    function automatic int unsigned ramp_length(input logic [16:0] d);
        if (d == 0)
            return 1;
        if (d > LAST_SECOND)
            return LAST_SECOND;
        return d;
    endfunction

    // True when t lies in [lo, hi]; hi past the end of the day wraps to the morning.
    function automatic bit in_window(input int unsigned t, input int unsigned lo,
                                     input int unsigned hi);
        return (lo <= t && t <= hi) || (hi >= SECS_PER_DAY && t <= hi - SECS_PER_DAY);
    endfunction

    // Works out the scale and segment for one time; unless start equals end, it updates the held scale.
    function automatic void predict_scale(input logic [31:0] tsec,
                                          output scale_result_t res);
        int unsigned     t;
        int unsigned     st;
        int unsigned     en;
        int unsigned     rise;
        int unsigned     fall;
        int unsigned     mn;
        int unsigned     inv;
        int unsigned     up_end;
        int unsigned     up_norm;
        int unsigned     dn_end;
        int unsigned     dn_norm;
        int unsigned     full_last;
        int unsigned     night_last;
        int unsigned     elapsed;
        longint unsigned s;

        t    = tsec % SECS_PER_DAY;
        st   = day_start_r % SECS_PER_DAY;
        en   = day_end_r % SECS_PER_DAY;
        rise = ramp_length(rise_time_r);
        fall = ramp_length(fall_time_r);
        mn   = (min_scale_r > SCALE_ONE) ? SCALE_ONE : min_scale_r;
        inv  = SCALE_ONE - mn;

        // Start equal to end repeats the last scale and keeps the state.
        if (st == en)
        begin
            res.scale = held_scale;
            res.ph    = PH_HELD;
            return;
        end

        up_end     = st + rise;
        up_norm    = (st + rise + 1) % SECS_PER_DAY;
        dn_end     = en + fall;
        dn_norm    = (en + fall + 1) % SECS_PER_DAY;
        full_last  = (en + SECS_PER_DAY - 1) % SECS_PER_DAY;
        if (full_last < up_norm)
            full_last += SECS_PER_DAY;
        night_last = (st + SECS_PER_DAY - 1) % SECS_PER_DAY;
        if (night_last < dn_norm)
            night_last += SECS_PER_DAY;

        if (in_window(t, st, up_end))
            res.ph = PH_RISE;
        else if (in_window(t, en, dn_end))
            res.ph = PH_FALL;
        else if (in_window(t, up_norm, full_last))
            res.ph = PH_FULL;
        else if (in_window(t, dn_norm, night_last))
            res.ph = PH_MIN;
        else
            res.ph = PH_OTHER;

        // Elapsed ramp time is taken modulo the day so midnight crossings count right.
        case (res.ph)
            PH_RISE, PH_OTHER:
            begin
                elapsed = (t + SECS_PER_DAY - st) % SECS_PER_DAY;
                s = elapsed;
                s = s * inv / rise + mn;
                if (s > SCALE_ONE)
                    s = SCALE_ONE;
            end
            PH_FALL:
            begin
                elapsed = (t + SECS_PER_DAY - en) % SECS_PER_DAY;
                s = elapsed;
                s = s * inv / fall;
                if (s > SCALE_ONE)
                    s = SCALE_ONE;
                s = SCALE_ONE - s;
            end
            PH_FULL:
                s = SCALE_ONE;
            default:
                s = mn;
        endcase

        held_scale = s[15:0];
        res.scale  = held_scale;
    endfunction

    // Counts a failure and reports the first few.
    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Lowers the input valid and waits until every expected scale has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_scales.size() != 0);
    endtask

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DAY_START: day_start_r = val;
            CFG_DAY_END:   day_end_r   = val;
            CFG_RISE_TIME: rise_time_r = val;
            CFG_FALL_TIME: fall_time_r = val;
            CFG_MIN_SCALE: min_scale_r = val[15:0];
            default:       ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one time, waits for the transfer, then queues the expected scale.
    task automatic send_time(input logic [31:0] tsec, input bit typed,
                             input logic [15:0] typed_scale, input phase_t typed_ph);
        scale_result_t res;

        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tsec;
        do
            @(posedge clk);
        while (!s_tready);

        predict_scale(tsec, res);
        if (typed)
        begin
            res.scale = typed_scale;
            res.ph    = typed_ph;
        end
        pending_scales.push_back(res);
    endtask

    // Random second of the day, with the ends and out-of-range values favored.
    function automatic logic [16:0] pick_second();
        case ($urandom_range(9))
            0:       return 17'd0;
            1:       return LAST_SECOND;
            2:       return 17'($urandom_range(86400, 131071));
            default: return 17'($urandom_range(0, 86399));
        endcase
    endfunction

    // Random ramp length, mostly short, with zero and the extremes mixed in.
    function automatic logic [16:0] pick_ramp();
        case ($urandom_range(9))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return LAST_SECOND;
            3:       return 17'($urandom_range(86400, 131071));
            4, 5:    return 17'($urandom_range(1, 300));
            default: return 17'($urandom_range(1, 20000));
        endcase
    endfunction

    // Random word, or a second near a ramp edge or anywhere, lifted by random days.
    function automatic logic [31:0] pick_time();
        int unsigned base;
        int unsigned tod;

        case ($urandom_range(11))
            0, 1, 2: return $urandom;
            3:       base = day_start_r;
            4:       base = day_start_r + ramp_length(rise_time_r);
            5:       base = day_end_r;
            6:       base = day_end_r + ramp_length(fall_time_r);
            7:       base = 0;
            default: base = $urandom_range(0, 86399);
        endcase
        tod = (base + SECS_PER_DAY - 2 + $urandom_range(4)) % SECS_PER_DAY;
        return tod + SECS_PER_DAY * $urandom_range(0, DAYS_IN_WORD);
    endfunction

    // Receiver: random stalls, or one long hold-off once it is requested.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Output checker and run watchdog.
    always @(posedge clk)
    begin
        scale_result_t exp_res;

        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scales.size() == 0)
                note_mismatch($sformatf("unexpected result scale %0d phase %0d",
                                        m_tdata, m_tuser));
            else
            begin
                exp_res = pending_scales.pop_front();
                if (m_tdata !== exp_res.scale || m_tuser !== exp_res.ph)
                    note_mismatch($sformatf("scale %0d phase %0d, expected %0d phase %0d",
                                            m_tdata, m_tuser, exp_res.scale,
                                            exp_res.ph));
            end
        end
    end

    // Stimulus: directed table, then random phases under different idling.
    initial
    begin
        int stall_pcts [4];
        int idle_pcts [4];
        int sent;

        idle_pcts  = '{0, 49, 0, 27};
        stall_pcts = '{0, 0, 49, 27};

        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DAY_START;
        cfg_data           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        day_start_r        = '0;
        day_end_r          = '0;
        rise_time_r        = RESET_RAMP;
        fall_time_r        = RESET_RAMP;
        min_scale_r        = RESET_MIN;
        held_scale         = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain_results();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                send_time(dir_rows[i].tsec, dir_rows[i].typed, dir_rows[i].scale,
                          dir_rows[i].ph);
        end

        // Random phases; the block is reconfigured between groups of items.
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_pcts[p];
            receiver_stall_pct = stall_pcts[p];
            sent = 0;
            while (sent < RANDOM_ITEMS / 4)
            begin
                drain_results();
                write_reg(CFG_DAY_START, pick_second());
                if ($urandom_range(7) == 0)
                    write_reg(CFG_DAY_END, day_start_r);
                else
                    write_reg(CFG_DAY_END, pick_second());
                write_reg(CFG_RISE_TIME, pick_ramp());
                write_reg(CFG_FALL_TIME, pick_ramp());
                case ($urandom_range(7))
                    0:       write_reg(CFG_MIN_SCALE, 17'd0);
                    1:       write_reg(CFG_MIN_SCALE, 17'(SCALE_ONE));
                    2:       write_reg(CFG_MIN_SCALE, 17'($urandom_range(32769, 131071)));
                    default: write_reg(CFG_MIN_SCALE, 17'($urandom_range(0, 32768)));
                endcase

                // Hold the receiver off once so the output register fills and
                // the input side stalls.
                if (p == 0 && sent == 0)
                    hold_req <= 1'b1;

                for (int k = 0; k < ITEMS_PER_CFG; k++)
                    send_time(pick_time(), 1'b0, 16'd0, PH_HELD);
                sent += ITEMS_PER_CFG;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_scales.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_scales.size()));

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
